>>> rtl/core/debounced_press_classifier_core_assert.svh
// Assertion macros used by the classifier stage (dpc_classify) of the debounced press classifier.
`ifndef DEBOUNCED_PRESS_CLASSIFIER_CORE_ASSERT_SVH
`define DEBOUNCED_PRESS_CLASSIFIER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Plain property, checked on every rising clock edge outside reset.
`define DPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define DPC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define DPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DPC_ASSERT(label, prop, msg)
`define DPC_ASSERT_IMPLY(label, ante, cons, msg)
`define DPC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/core/dpc_pkg.sv
// Types and constants shared by the debounced press classifier modules.
`timescale 1ns / 1ps

package dpc_pkg;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		CFG_DEBOUNCE_LIMIT = 2'd0,
		CFG_SHORT_THRESHOLD = 2'd1,
		CFG_LONG_THRESHOLD = 2'd2
	} cfg_idx_t;

	// Click codes carried on the result stream.
	typedef enum logic {
		CLICK_SHORT = 1'b0,
		CLICK_LONG = 1'b1
	} click_kind_t;

	localparam int TIME_W = 63;
	localparam int LIMIT_W = 8;
	localparam int THR_MS_W = 16;
	localparam int THR_US_W = 26;
	localparam int CFG_DATA_W = 16;

	localparam logic [9:0] US_PER_MS = 10'd1000;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd5;
	localparam logic [THR_US_W-1:0] SHORT_US_RESET = 26'd50000;
	localparam logic [THR_US_W-1:0] LONG_US_RESET = 26'd1000000;

	// Active settings, thresholds already scaled to microseconds.
	typedef struct packed {
		logic [LIMIT_W-1:0] debounce_limit;
		logic [THR_US_W-1:0] short_us;
		logic [THR_US_W-1:0] long_us;
	} cfg_t;

	// One pin poll held in the input register.
	typedef struct packed {
		logic pin_high;
		logic [TIME_W-1:0] now_us;
	} poll_t;

endpackage

>>> rtl/core/dpc_cfg.sv
// Configuration registers with thresholds scaled to microseconds on write.
`timescale 1ns / 1ps

module dpc_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [dpc_pkg::CFG_DATA_W-1:0] cfg_data,
	output dpc_pkg::cfg_t cfg
);

	logic [dpc_pkg::LIMIT_W-1:0] limit_q;
	logic [dpc_pkg::THR_US_W-1:0] short_us_q;
	logic [dpc_pkg::THR_US_W-1:0] long_us_q;
	logic [dpc_pkg::THR_US_W-1:0] data_us;

	// Writes are always taken.
	assign cfg_ready = 1'b1;

	// Milliseconds to microseconds, one narrow constant multiply at the full product width.
	assign data_us = dpc_pkg::THR_US_W'(cfg_data) * dpc_pkg::THR_US_W'(dpc_pkg::US_PER_MS);

	// Register file; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= dpc_pkg::LIMIT_RESET;
			short_us_q <= dpc_pkg::SHORT_US_RESET;
			long_us_q <= dpc_pkg::LONG_US_RESET;
		end else if (cfg_valid) begin
			unique case (dpc_pkg::cfg_idx_t'(cfg_index))
				dpc_pkg::CFG_DEBOUNCE_LIMIT: begin
					limit_q <= cfg_data[dpc_pkg::LIMIT_W-1:0];
				end
				dpc_pkg::CFG_SHORT_THRESHOLD: begin
					short_us_q <= data_us;
				end
				dpc_pkg::CFG_LONG_THRESHOLD: begin
					long_us_q <= data_us;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.debounce_limit = limit_q;
	assign cfg.short_us = short_us_q;
	assign cfg.long_us = long_us_q;

endmodule

>>> rtl/core/dpc_in_stage.sv
// Input register that holds one pin poll until the classifier takes it.
`timescale 1ns / 1ps

module dpc_in_stage (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic take,
	output logic valid_s1,
	output dpc_pkg::poll_t poll_s1
);

	logic valid_q;
	dpc_pkg::poll_t poll_q;

	// Room when empty or when the held poll leaves this cycle.
	assign s_axis_tready = !valid_q || take;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			valid_q <= s_axis_tvalid;
		end
	end

	// Payload capture.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			poll_q.pin_high <= s_axis_tdata[0];
			poll_q.now_us <= s_axis_tdata[dpc_pkg::TIME_W:1];
		end
	end

	assign valid_s1 = valid_q;
	assign poll_s1 = poll_q;

endmodule

>>> rtl/core/dpc_classify.sv
// Debounce integrator, press timing and click classification with result register.
`timescale 1ns / 1ps
`include "debounced_press_classifier_core_assert.svh"

module dpc_classify (
	input logic clk,
	input logic arst_n,
	input dpc_pkg::cfg_t cfg,
	input logic valid_s1,
	input dpc_pkg::poll_t poll_s1,
	output logic take,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [7:0] m_axis_tdata
);

	logic [dpc_pkg::LIMIT_W-1:0] integ_q;
	logic level_q;
	logic [dpc_pkg::TIME_W-1:0] start_q;
	logic out_valid_q;
	dpc_pkg::click_kind_t kind_q;

	logic [dpc_pkg::LIMIT_W-1:0] limit_eff;
	logic [dpc_pkg::LIMIT_W-1:0] integ_nxt;
	logic press;
	logic release_ev;
	logic [dpc_pkg::TIME_W-1:0] len_us;
	logic [dpc_pkg::TIME_W-1:0] short_ext;
	logic [dpc_pkg::TIME_W-1:0] long_ext;
	logic is_short;
	logic is_long;
	logic advance;
	logic res_load;

	// A poll is consumed when the result register can accept whatever it yields.
	assign take = !out_valid_q || m_axis_tready;
	assign advance = valid_s1 && take;

	// A zero limit behaves as one.
	assign limit_eff = (cfg.debounce_limit == '0) ? dpc_pkg::LIMIT_W'(1) : cfg.debounce_limit;

	// Saturating integrator step.
	always_comb begin
		if (poll_s1.pin_high) begin
			integ_nxt = (integ_q < limit_eff) ? integ_q + dpc_pkg::LIMIT_W'(1) : limit_eff;
		end else begin
			integ_nxt = (integ_q != '0) ? integ_q - dpc_pkg::LIMIT_W'(1) : integ_q;
		end
	end

	// Level transitions; press wins over release.
	assign press = (integ_nxt == limit_eff) && !level_q;
	assign release_ev = !press && (integ_nxt == '0) && level_q;

	// Press length wraps modulo the time width.
	assign len_us = poll_s1.now_us - start_q;
	assign short_ext = dpc_pkg::TIME_W'(cfg.short_us);
	assign long_ext = dpc_pkg::TIME_W'(cfg.long_us);
	assign is_long = (len_us >= long_ext);
	assign is_short = (len_us > short_ext) && !is_long;

	assign res_load = advance && release_ev && (is_short || is_long);

	// Debounce state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			level_q <= 1'b0;
			start_q <= '0;
		end else if (advance) begin
			integ_q <= integ_nxt;
			if (press) begin
				level_q <= 1'b1;
				start_q <= poll_s1.now_us;
			end else if (release_ev) begin
				level_q <= 1'b0;
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			kind_q <= is_long ? dpc_pkg::CLICK_LONG : dpc_pkg::CLICK_SHORT;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {7'd0, kind_q};

	// A click is only reported on the release that clears the level.
	`DPC_ASSERT_NEXT(a_click_clears_level, res_load, !level_q, "click without release")
	// A press records the poll time.
	`DPC_ASSERT_NEXT(a_press_records_time, advance && press,
		level_q && (start_q == $past(poll_s1.now_us)), "press time not recorded")
	// Below the limit a high poll counts up by exactly one.
	`DPC_ASSERT_NEXT(a_integ_step_up, advance && poll_s1.pin_high && (integ_q < limit_eff),
		integ_q == $past(integ_q) + dpc_pkg::LIMIT_W'(1), "integrator step up wrong")
	// Without a consumed poll the debounce state holds.
	`DPC_ASSERT_NEXT(a_state_holds, !advance,
		$stable(integ_q) && $stable(level_q) && $stable(start_q), "state moved while idle")

endmodule

>>> rtl/core/debounced_press_classifier_core.sv
// Top level of the debounced button press classifier.
`timescale 1ns / 1ps

// Usage:
// Each input beat on s_axis is one poll of a button pin plus the current time
// in microseconds. A saturating integrator debounces the pin; on a stable
// release the press length is measured and classified. A short or long click
// leaves as one beat on m_axis; other releases and all other polls yield none.
// Order: a poll is registered on acceptance; its click, if any, is registered
// in the result register once the classifier takes it from the input register.
// Throughput: one poll per cycle while no click is held on m_axis, set by the
// single compute stage between the input register and the result register.
// Backpressure: while a click waits on m_axis, the next poll is still taken
// into the input register; polls stall only when both registers are held.
// The cfg channel is always ready; thresholds are scaled to microseconds as
// they are written. Reset restores limit 5, short 50 ms, long 1000 ms, clears
// the integrator, the debounced level and the press time, and empties both
// registers.

module debounced_press_classifier_core (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// Fields from bit 0: pin_high [0], now_us [63:1].
	input logic [63:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// Fields from bit 0: click_kind [0], zero fill [7:1].
	output logic [7:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	dpc_pkg::cfg_t cfg;
	dpc_pkg::poll_t poll_s1;
	logic valid_s1;
	logic take;

	dpc_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	dpc_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.take(take),
		.valid_s1(valid_s1),
		.poll_s1(poll_s1)
	);

	dpc_classify u_classify (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.valid_s1(valid_s1),
		.poll_s1(poll_s1),
		.take(take),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

endmodule
